// File: design/signed_decimal_to_fixed_point_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the decimal to fixed-point converter.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_TO_FIXED_POINT_ASSERT_SVH
`define SIGNED_DECIMAL_TO_FIXED_POINT_ASSERT_SVH

`ifndef ASSERT_OFF
`define SDFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SDFP_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SDFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SDFP_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: design/sdfp_pkg.sv
// ----------------------------------------------------------------------------
// sdfp_pkg
// Types, character codes and helper functions for the decimal converter.
// ----------------------------------------------------------------------------
package sdfp_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int PREC_BITS      = 3;
    localparam int POW_BITS       = 24;
    localparam int PROD_BITS      = VALUE_BITS + POW_BITS;
    localparam int WIDE_BITS      = VALUE_BITS + 4;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_CNT_BITS = 2;

    localparam logic [PREC_BITS-1:0] PREC_RESET = 3'd1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    localparam logic [VALUE_BITS-1:0] MAG_MAX_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] MAG_MAX_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_INT_DIGIT,
        OP_FRAC_DIGIT,
        OP_SIGN_NEG,
        OP_SIGN_POS,
        OP_POINT,
        OP_TERM
    } sdfp_op_t;

    typedef struct packed {
        sdfp_op_t    op;
        logic [3:0]  digit;
    } sdfp_cmd_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] mag;
        logic                  neg;
        logic                  digits;
        logic                  sat;
        logic [PREC_BITS-1:0]  scale;
    } sdfp_term_t;

    function automatic logic [VALUE_BITS-1:0] mag_limit(input logic neg);
        return neg ? MAG_MAX_NEG : MAG_MAX_POS;
    endfunction

    function automatic logic [POW_BITS-1:0] pow10(input logic [PREC_BITS-1:0] k);
        logic [POW_BITS-1:0] p;
        unique case (k)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

endpackage

// File: design/signed_decimal_to_fixed_point.sv
// ----------------------------------------------------------------------------
// signed_decimal_to_fixed_point
// Streaming converter from signed ASCII decimal text to fixed-point integers.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   s_char_code (one character)
//   m_        out        m_valid / m_ready   m_value, m_had_digits, m_overflow
//   cfg_      in         cfg_we              cfg_wdata (precision)
//
// One character is taken every cycle while s_ready is high; digit accumulation
// is one multiply by ten and add per cycle in the execution stage.
// A result passes the command queue, product register and output register.
// Reset sets precision to one and clears the accumulated number state.
// A stalled result holds the scaling pipeline, and the two-entry command
// queue then fills before s_ready falls.
// ----------------------------------------------------------------------------
module signed_decimal_to_fixed_point (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [sdfp_pkg::PREC_BITS-1:0]         cfg_wdata,
    input  logic [7:0]                             s_char_code,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    output logic signed [sdfp_pkg::VALUE_BITS-1:0] m_value,
    output logic                                   m_had_digits,
    output logic                                   m_overflow,
    output logic                                   m_valid,
    input  logic                                   m_ready
);
    import sdfp_pkg::*;

    logic [PREC_BITS-1:0] prec_reg;
    logic                 accept;
    sdfp_cmd_t            front_cmd;
    logic                 head_valid;
    sdfp_cmd_t            head_cmd;
    logic                 cmd_pop;
    logic                 term_valid;
    sdfp_term_t           term;
    logic                 term_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prec_reg <= PREC_RESET;
        end else if (cfg_we) begin
            prec_reg <= cfg_wdata;
        end
    end

    assign accept = s_valid && s_ready;

    sdfp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .char_code (s_char_code),
        .accept    (accept),
        .cmd       (front_cmd)
    );

    sdfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_cmd   (front_cmd),
        .space      (s_ready),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    sdfp_exec u_exec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .precision  (prec_reg),
        .cmd_valid  (head_valid),
        .cmd        (head_cmd),
        .cmd_pop    (cmd_pop),
        .term_valid (term_valid),
        .term       (term),
        .term_ready (term_ready)
    );

    sdfp_finish u_finish (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (term_valid),
        .in_term      (term),
        .in_ready     (term_ready),
        .m_value      (m_value),
        .m_had_digits (m_had_digits),
        .m_overflow   (m_overflow),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule

// File: design/sdfp_front.sv
// ----------------------------------------------------------------------------
// sdfp_front
// Classifies each incoming character into a command for the execution stage.
// ----------------------------------------------------------------------------
module sdfp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           char_code,
    input  logic                 accept,
    output sdfp_pkg::sdfp_cmd_t  cmd
);
    import sdfp_pkg::*;

    logic past_start_reg, past_start_next;
    logic in_frac_reg, in_frac_next;
    logic is_digit;

    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

    always_comb begin
        cmd.digit       = 4'(char_code - CHAR_ZERO);
        past_start_next = past_start_reg;
        in_frac_next    = in_frac_reg;
        priority if (is_digit) begin
            cmd.op          = in_frac_reg ? OP_FRAC_DIGIT : OP_INT_DIGIT;
            past_start_next = 1'b1;
        end else if (!past_start_reg && char_code == CHAR_MINUS) begin
            cmd.op          = OP_SIGN_NEG;
            past_start_next = 1'b1;
        end else if (!past_start_reg && char_code == CHAR_PLUS) begin
            cmd.op          = OP_SIGN_POS;
            past_start_next = 1'b1;
        end else if (char_code == CHAR_POINT && !in_frac_reg) begin
            cmd.op          = OP_POINT;
            past_start_next = 1'b1;
            in_frac_next    = 1'b1;
        end else begin
            cmd.op          = OP_TERM;
            past_start_next = 1'b0;
            in_frac_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            past_start_reg <= 1'b0;
            in_frac_reg    <= 1'b0;
        end else if (accept) begin
            past_start_reg <= past_start_next;
            in_frac_reg    <= in_frac_next;
        end
    end

endmodule

// File: design/sdfp_queue.sv
// ----------------------------------------------------------------------------
// sdfp_queue
// Short command queue that decouples the classifier from the execution stage.
// ----------------------------------------------------------------------------
`include "signed_decimal_to_fixed_point_assert.svh"

module sdfp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  sdfp_pkg::sdfp_cmd_t  push_cmd,
    output logic                 space,
    input  logic                 pop,
    output logic                 head_valid,
    output sdfp_pkg::sdfp_cmd_t  head_cmd
);
    import sdfp_pkg::*;

    localparam logic [QUEUE_CNT_BITS-1:0] FULL = QUEUE_CNT_BITS'(QUEUE_DEPTH);

    sdfp_cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;

    assign space      = (count_reg != FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `SDFP_NEVER(q_no_push_full, aclk, aresetn, push && count_reg == FULL, "push into full queue")
    `SDFP_NEVER(q_no_pop_empty, aclk, aresetn, pop && count_reg == '0, "pop from empty queue")

endmodule

// File: design/sdfp_exec.sv
// ----------------------------------------------------------------------------
// sdfp_exec
// Carries out commands: accumulates digits with saturation and hands each
// finished number to the scaling pipeline.
// ----------------------------------------------------------------------------
`include "signed_decimal_to_fixed_point_assert.svh"

module sdfp_exec (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [sdfp_pkg::PREC_BITS-1:0]      precision,
    input  logic                                cmd_valid,
    input  sdfp_pkg::sdfp_cmd_t                 cmd,
    output logic                                cmd_pop,
    output logic                                term_valid,
    output sdfp_pkg::sdfp_term_t                term,
    input  logic                                term_ready
);
    import sdfp_pkg::*;

    logic [VALUE_BITS-1:0] running_reg, running_next;
    logic                  neg_reg, neg_next;
    logic [PREC_BITS-1:0]  fd_reg, fd_next;
    logic                  seen_reg, seen_next;
    logic                  sat_reg, sat_next;
    logic [VALUE_BITS-1:0] lim;
    logic [WIDE_BITS-1:0]  ext, acc;
    logic                  acc_over;
    logic                  frac_keep;

    assign lim       = mag_limit(neg_reg);
    assign ext       = WIDE_BITS'(running_reg);
    assign acc       = (ext << 3) + (ext << 1) + WIDE_BITS'(cmd.digit);
    assign acc_over  = acc > WIDE_BITS'(lim);
    assign frac_keep = fd_reg < precision;

    assign term_valid = cmd_valid && (cmd.op == OP_TERM);
    assign cmd_pop    = cmd_valid && ((cmd.op != OP_TERM) || term_ready);

    always_comb begin
        term.mag    = running_reg;
        term.neg    = neg_reg;
        term.digits = seen_reg;
        term.sat    = sat_reg;
        term.scale  = frac_keep ? PREC_BITS'(precision - fd_reg) : '0;
    end

    always_comb begin
        running_next = running_reg;
        neg_next     = neg_reg;
        fd_next      = fd_reg;
        seen_next    = seen_reg;
        sat_next     = sat_reg;
        unique case (cmd.op)
            OP_INT_DIGIT: begin
                seen_next    = 1'b1;
                running_next = acc_over ? lim : acc[VALUE_BITS-1:0];
                sat_next     = sat_reg | acc_over;
            end
            OP_FRAC_DIGIT: begin
                seen_next = 1'b1;
                if (frac_keep) begin
                    running_next = acc_over ? lim : acc[VALUE_BITS-1:0];
                    sat_next     = sat_reg | acc_over;
                    fd_next      = fd_reg + 1'b1;
                end
            end
            OP_SIGN_NEG: neg_next = 1'b1;
            OP_SIGN_POS: neg_next = 1'b0;
            OP_POINT: begin
            end
            OP_TERM: begin
                running_next = '0;
                neg_next     = 1'b0;
                fd_next      = '0;
                seen_next    = 1'b0;
                sat_next     = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= '0;
            neg_reg     <= 1'b0;
            fd_reg      <= '0;
            seen_reg    <= 1'b0;
            sat_reg     <= 1'b0;
        end else if (cmd_pop) begin
            running_reg <= running_next;
            neg_reg     <= neg_next;
            fd_reg      <= fd_next;
            seen_reg    <= seen_next;
            sat_reg     <= sat_next;
        end
    end

    `SDFP_ASSERT(ex_sat_at_limit, aclk, aresetn, sat_reg |-> running_reg == lim, "saturated value off limit")

endmodule

// File: design/sdfp_finish.sv
// ----------------------------------------------------------------------------
// sdfp_finish
// Pads the kept fraction by a power of ten, saturates, applies the sign and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
`include "signed_decimal_to_fixed_point_assert.svh"

module sdfp_finish (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  sdfp_pkg::sdfp_term_t                 in_term,
    output logic                                 in_ready,
    output logic signed [sdfp_pkg::VALUE_BITS-1:0] m_value,
    output logic                                 m_had_digits,
    output logic                                 m_overflow,
    output logic                                 m_valid,
    input  logic                                 m_ready
);
    import sdfp_pkg::*;

    logic                  a_valid_reg;
    logic [PROD_BITS-1:0]  a_prod_reg;
    logic                  a_neg_reg;
    logic                  a_digits_reg;
    logic                  a_sat_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  digits_reg;
    logic                  ovf_reg;
    logic                  load_out;
    logic [VALUE_BITS-1:0] lim;
    logic                  pad_over;
    logic [VALUE_BITS-1:0] mag;

    assign load_out = a_valid_reg && (!out_valid_reg || m_ready);
    assign in_ready = !a_valid_reg || load_out;

    assign lim      = mag_limit(a_neg_reg);
    assign pad_over = a_prod_reg > PROD_BITS'(lim);
    assign mag      = pad_over ? lim : a_prod_reg[VALUE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            a_prod_reg   <= PROD_BITS'(in_term.mag) * PROD_BITS'(pow10(in_term.scale));
            a_neg_reg    <= in_term.neg;
            a_digits_reg <= in_term.digits;
            a_sat_reg    <= in_term.sat;
        end
        if (load_out) begin
            value_reg  <= a_neg_reg ? ('0 - mag) : mag;
            digits_reg <= a_digits_reg;
            ovf_reg    <= a_sat_reg | pad_over;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                a_valid_reg <= in_valid;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_value      = $signed(value_reg);
    assign m_had_digits = digits_reg;
    assign m_overflow   = ovf_reg;
    assign m_valid      = out_valid_reg;

    `SDFP_ASSERT(fin_ovf_limit, aclk, aresetn, out_valid_reg && ovf_reg |-> value_reg == MAG_MAX_POS || value_reg == MAG_MAX_NEG, "overflow without limit value")
    `SDFP_ASSERT(fin_empty_zero, aclk, aresetn, out_valid_reg && !digits_reg |-> value_reg == '0 && !ovf_reg, "empty number not zero")

endmodule
